FILE: hdl/gom_pkg.sv
package gom_pkg;

   localparam int REQ_TYPE_W  = 2;
   localparam int COORD_W     = 6;
   localparam int SIZE_W      = 7;
   localparam int COUNT_W     = 14;
   localparam int TOTAL_W     = 13;
   localparam int NBR_W       = 3;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int EXT_W       = 11;
   localparam int PROBE_W     = 3;

   localparam int MAX_ROWS_DEFAULT = 64;
   localparam int MAX_COLS_DEFAULT = 64;

   localparam logic [SIZE_W-1:0]  SIZE_RESET = 7'd64;
   localparam logic [COUNT_W-1:0] MIN_CELLS  = 14'd4;

   localparam logic [REQ_TYPE_W-1:0] REQ_WRITE = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_COUNT = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OOB   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SAME  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_SMALL = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_ROWS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_COLS = 1'd1;

   localparam logic [PROBE_W-1:0] PROBE_CENTER = 3'd0;
   localparam logic [PROBE_W-1:0] PROBE_UP     = 3'd1;
   localparam logic [PROBE_W-1:0] PROBE_DOWN   = 3'd2;
   localparam logic [PROBE_W-1:0] PROBE_LEFT   = 3'd3;
   localparam logic [PROBE_W-1:0] PROBE_RIGHT  = 3'd4;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [COORD_W-1:0]    cell_row;
      logic [COORD_W-1:0]    cell_col;
      logic                  new_blocked;
   } request_type;

   typedef struct packed {
      logic                  cell_blocked;
      logic [NBR_W-1:0]      free_neighbours;
      logic [TOTAL_W-1:0]    blocked_total;
      logic [TOTAL_W-1:0]    free_total;
      logic [STATUS_W-1:0]   status;
   } response_type;

endpackage

FILE: hdl/grid_occupancy_map_core.sv
// Reads and writes pass through the probe, wait and done states; a neighbour count probes the
// centre, up, down, left and right cells before waiting; clear, out-of-bounds and too-small
// requests go straight to done. One request at a time; the bit memory reads one cell a cycle.
// Reset (synchronous, active high) and any clear or size write with blocked cells start a sweep
// that zeroes 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) cells, one a cycle (4096 by default);
// req_stall stays high during the sweep.
module grid_occupancy_map_core #(
   parameter int MAX_ROWS = gom_pkg::MAX_ROWS_DEFAULT,
   parameter int MAX_COLS = gom_pkg::MAX_COLS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  gom_pkg::request_type                 req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output gom_pkg::response_type                rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gom_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [gom_pkg::SIZE_W-1:0]           csr_data
);

   localparam int RW     = $clog2(MAX_ROWS);
   localparam int CW     = $clog2(MAX_COLS);
   localparam int ADDR_W = RW + CW;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_PROBE = 2'd1;
   localparam logic [1:0] S_WAIT  = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic [gom_pkg::SIZE_W-1:0]      rows_ff, rows_in;
   logic [gom_pkg::SIZE_W-1:0]      cols_ff, cols_in;
   logic [gom_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic                            sweep_ff, sweep_in;
   logic [ADDR_W-1:0]               sweep_addr_ff, sweep_addr_in;
   gom_pkg::request_type            req_ff, req_in;
   logic [gom_pkg::PROBE_W-1:0]     probe_ff, probe_in;
   logic                            rd_valid_ff, rd_valid_in;
   logic [gom_pkg::PROBE_W-1:0]     rd_probe_ff, rd_probe_in;
   logic                            rd_use_ff, rd_use_in;
   logic                            blk_ff, blk_in;
   logic [gom_pkg::NBR_W-1:0]       nbr_ff, nbr_in;
   gom_pkg::response_type           res_ff, res_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   gom_pkg::response_type           rsp_data_ff, rsp_data_in;

   logic                            mem_we;
   logic [ADDR_W-1:0]               mem_wa;
   logic                            mem_wd;
   logic [ADDR_W-1:0]               mem_ra;
   logic                            mem_rd;

   logic [gom_pkg::COUNT_W-1:0]     total;
   logic [gom_pkg::COUNT_W-1:0]     free_cnt;
   logic [gom_pkg::SIZE_W-1:0]      row_sel;
   logic [gom_pkg::SIZE_W-1:0]      col_sel;
   logic [gom_pkg::EXT_W-1:0]       row_ext;
   logic [gom_pkg::EXT_W-1:0]       col_ext;
   logic [gom_pkg::EXT_W-1:0]       csr_ext;
   logic [gom_pkg::SIZE_W-1:0]      csr_rows;
   logic [gom_pkg::SIZE_W-1:0]      csr_cols;
   logic [gom_pkg::SIZE_W-1:0]      in_row;
   logic [gom_pkg::SIZE_W-1:0]      in_col;
   logic [gom_pkg::SIZE_W-1:0]      cur_row;
   logic [gom_pkg::SIZE_W-1:0]      cur_col;
   logic                            probe_use;
   logic                            blk_now;
   logic                            res_load;

   assign total    = gom_pkg::COUNT_W'(rows_ff) * gom_pkg::COUNT_W'(cols_ff);
   assign free_cnt = total - count_in;

   assign csr_ext  = gom_pkg::EXT_W'(csr_data);
   assign csr_rows = (csr_ext > gom_pkg::EXT_W'(MAX_ROWS)) ?
                     gom_pkg::SIZE_W'(MAX_ROWS) : csr_data;
   assign csr_cols = (csr_ext > gom_pkg::EXT_W'(MAX_COLS)) ?
                     gom_pkg::SIZE_W'(MAX_COLS) : csr_data;

   assign in_row  = gom_pkg::SIZE_W'(req_data.cell_row);
   assign in_col  = gom_pkg::SIZE_W'(req_data.cell_col);
   assign cur_row = gom_pkg::SIZE_W'(req_ff.cell_row);
   assign cur_col = gom_pkg::SIZE_W'(req_ff.cell_col);

   always_comb begin
      row_sel   = cur_row;
      col_sel   = cur_col;
      probe_use = 1'b1;
      case (probe_ff)
         gom_pkg::PROBE_CENTER: begin
            probe_use = 1'b1;
         end
         gom_pkg::PROBE_UP: begin
            row_sel   = cur_row - 7'd1;
            probe_use = (cur_row != 7'd0);
         end
         gom_pkg::PROBE_DOWN: begin
            row_sel   = cur_row + 7'd1;
            probe_use = (row_sel < rows_ff);
         end
         gom_pkg::PROBE_LEFT: begin
            col_sel   = cur_col - 7'd1;
            probe_use = (cur_col != 7'd0);
         end
         gom_pkg::PROBE_RIGHT: begin
            col_sel   = cur_col + 7'd1;
            probe_use = (col_sel < cols_ff);
         end
         default: begin
            probe_use = 1'b0;
         end
      endcase
   end

   assign row_ext = gom_pkg::EXT_W'(row_sel);
   assign col_ext = gom_pkg::EXT_W'(col_sel);
   assign mem_ra  = {row_ext[RW-1:0], col_ext[CW-1:0]};

   assign blk_now = (rd_probe_ff == gom_pkg::PROBE_CENTER) ? mem_rd : blk_ff;

   always_comb begin
      state_in      = state_ff;
      rows_in       = rows_ff;
      cols_in       = cols_ff;
      count_in      = count_ff;
      sweep_in      = sweep_ff;
      sweep_addr_in = sweep_addr_ff;
      req_in        = req_ff;
      probe_in      = probe_ff;
      rd_valid_in   = 1'b0;
      rd_probe_in   = rd_probe_ff;
      rd_use_in     = rd_use_ff;
      blk_in        = blk_ff;
      nbr_in        = nbr_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_wa        = mem_ra;
      mem_wd        = 1'b0;
      res_load      = 1'b0;

      if (rd_valid_ff) begin
         if (rd_probe_ff == gom_pkg::PROBE_CENTER) begin
            blk_in = mem_rd;
         end else if (rd_use_ff && !mem_rd) begin
            nbr_in = nbr_ff + 3'd1;
         end
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid && !sweep_ff) begin
               req_in   = req_data;
               blk_in   = 1'b0;
               nbr_in   = '0;
               probe_in = gom_pkg::PROBE_CENTER;
               res_in   = '0;
               if (total < gom_pkg::MIN_CELLS) begin
                  res_in.status = gom_pkg::STATUS_SMALL;
                  res_load      = 1'b1;
                  state_in      = S_DONE;
               end else if (req_data.req_type == gom_pkg::REQ_CLEAR) begin
                  if (count_ff == '0) begin
                     res_in.status = gom_pkg::STATUS_SAME;
                  end else begin
                     res_in.status = gom_pkg::STATUS_OK;
                     count_in      = '0;
                     sweep_in      = 1'b1;
                     sweep_addr_in = '0;
                  end
                  res_load = 1'b1;
                  state_in = S_DONE;
               end else if (in_row >= rows_ff || in_col >= cols_ff) begin
                  res_in.status = gom_pkg::STATUS_OOB;
                  res_load      = 1'b1;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            rd_valid_in = 1'b1;
            rd_probe_in = probe_ff;
            rd_use_in   = probe_use;
            if (req_ff.req_type != gom_pkg::REQ_COUNT ||
                probe_ff == gom_pkg::PROBE_RIGHT) begin
               state_in = S_WAIT;
            end else begin
               probe_in = probe_ff + 3'd1;
            end
         end
         S_WAIT: begin
            res_in                 = '0;
            res_in.cell_blocked    = blk_now;
            res_in.status          = gom_pkg::STATUS_OK;
            if (req_ff.req_type == gom_pkg::REQ_COUNT) begin
               res_in.free_neighbours = nbr_in;
            end
            if (req_ff.req_type == gom_pkg::REQ_WRITE) begin
               if (blk_now == req_ff.new_blocked) begin
                  res_in.status = gom_pkg::STATUS_SAME;
               end else begin
                  mem_we              = 1'b1;
                  mem_wd              = req_ff.new_blocked;
                  res_in.cell_blocked = req_ff.new_blocked;
                  count_in = req_ff.new_blocked ? count_ff + 14'd1 : count_ff - 14'd1;
               end
            end
            res_load = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (sweep_ff) begin
         mem_we        = 1'b1;
         mem_wa        = sweep_addr_ff;
         mem_wd        = 1'b0;
         sweep_addr_in = sweep_addr_ff + ADDR_W'(1);
         if (sweep_addr_ff == '1) begin
            sweep_in = 1'b0;
         end
      end

      if (csr_valid) begin
         if (csr_index == gom_pkg::CSR_GRID_ROWS) begin
            rows_in = csr_rows;
         end else begin
            cols_in = csr_cols;
         end
         count_in = '0;
         if (count_ff != '0) begin
            sweep_in      = 1'b1;
            sweep_addr_in = '0;
         end
      end

      if (res_load) begin
         res_in.blocked_total = count_in[gom_pkg::TOTAL_W-1:0];
         res_in.free_total    = free_cnt[gom_pkg::TOTAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rows_ff       <= (MAX_ROWS < 64) ? gom_pkg::SIZE_W'(MAX_ROWS) : gom_pkg::SIZE_RESET;
         cols_ff       <= (MAX_COLS < 64) ? gom_pkg::SIZE_W'(MAX_COLS) : gom_pkg::SIZE_RESET;
         count_ff      <= '0;
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
         probe_ff      <= gom_pkg::PROBE_CENTER;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rows_ff       <= rows_in;
         cols_ff       <= cols_in;
         count_ff      <= count_in;
         sweep_ff      <= sweep_in;
         sweep_addr_ff <= sweep_addr_in;
         probe_ff      <= probe_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_ff      <= req_in;
      rd_probe_ff <= rd_probe_in;
      rd_use_ff   <= rd_use_in;
      blk_ff      <= blk_in;
      nbr_ff      <= nbr_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   gom_mem #(
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   assign req_stall = sweep_ff || (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

FILE: hdl/gom_mem.sv
module gom_mem #(
   parameter int ADDR_W = $clog2(gom_pkg::MAX_ROWS_DEFAULT) + $clog2(gom_pkg::MAX_COLS_DEFAULT)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic              wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic              rd_data
);

   logic mem_ff [2**ADDR_W];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/sv/grid_occupancy_map_core_tb.sv
module grid_occupancy_map_core_tb;

   localparam int STALL_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 12;
   localparam int LONG_HOLD     = 400;
   localparam int GRID_CELLS    = 4096;

   typedef struct {
      bit                                 is_csr;
      logic [gom_pkg::CSR_INDEX_W-1:0]    reg_index;
      logic [gom_pkg::SIZE_W-1:0]         reg_value;
      gom_pkg::request_type               rq;
      bit                                 typed;
      gom_pkg::response_type              rsp;
   } stim_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   gom_pkg::request_type            req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   gom_pkg::response_type           rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [gom_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [gom_pkg::SIZE_W-1:0]      csr_data = '0;

   bit                              occ_map [0:GRID_CELLS-1];
   int unsigned                     blocked_cnt;
   logic [gom_pkg::SIZE_W-1:0]      rows_reg;
   logic [gom_pkg::SIZE_W-1:0]      cols_reg;

   gom_pkg::response_type           pending_responses[$];
   stim_row_type                    plan[$];
   int unsigned                     mismatch_count = 0;
   int unsigned                     idle_cycles = 0;
   bit                              hold_rsp = 1'b0;

   grid_occupancy_map_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   function automatic int unsigned eff_size(logic [gom_pkg::SIZE_W-1:0] v);
      return (v > 64) ? 64 : int'(v);
   endfunction

   function automatic void wipe_grid();
      for (int i = 0; i < GRID_CELLS; i++) occ_map[i] = 1'b0;
      blocked_cnt = 0;
   endfunction

   function automatic gom_pkg::response_type predict_grid_response(gom_pkg::request_type rq);
      int unsigned rows;
      int unsigned cols;
      int unsigned total;
      int unsigned r;
      int unsigned c;
      int unsigned idx;
      int unsigned nbr;
      int unsigned free_cnt;
      gom_pkg::response_type rs;
      rows = eff_size(rows_reg);
      cols = eff_size(cols_reg);
      total = rows * cols;
      r = 32'(rq.cell_row);
      c = 32'(rq.cell_col);
      nbr = 0;
      rs = '0;
      rs.status = gom_pkg::STATUS_OK;
      if (total < gom_pkg::MIN_CELLS) begin
         rs.status = gom_pkg::STATUS_SMALL;
      end else if (rq.req_type == gom_pkg::REQ_CLEAR) begin
         if (blocked_cnt == 0) rs.status = gom_pkg::STATUS_SAME;
         else wipe_grid();
      end else if (r >= rows || c >= cols) begin
         rs.status = gom_pkg::STATUS_OOB;
      end else begin
         idx = r * cols + c;
         rs.cell_blocked = occ_map[idx];
         if (rq.req_type == gom_pkg::REQ_WRITE) begin
            if (rs.cell_blocked == rq.new_blocked) begin
               rs.status = gom_pkg::STATUS_SAME;
            end else begin
               occ_map[idx] = rq.new_blocked;
               if (rq.new_blocked) blocked_cnt++;
               else blocked_cnt--;
               rs.cell_blocked = rq.new_blocked;
            end
         end else if (rq.req_type == gom_pkg::REQ_COUNT) begin
            if (r > 0 && !occ_map[idx - cols]) nbr++;
            if (r + 1 < rows && !occ_map[idx + cols]) nbr++;
            if (c > 0 && !occ_map[idx - 1]) nbr++;
            if (c + 1 < cols && !occ_map[idx + 1]) nbr++;
         end
      end
      free_cnt = total - blocked_cnt;
      rs.free_neighbours = nbr[gom_pkg::NBR_W-1:0];
      rs.blocked_total = blocked_cnt[gom_pkg::TOTAL_W-1:0];
      rs.free_total = free_cnt[gom_pkg::TOTAL_W-1:0];
      return rs;
   endfunction

   function automatic gom_pkg::request_type make_request(logic [1:0] kind, int unsigned row,
                                                         int unsigned col, bit nb);
      gom_pkg::request_type rq;
      rq.req_type = kind;
      rq.cell_row = row[gom_pkg::COORD_W-1:0];
      rq.cell_col = col[gom_pkg::COORD_W-1:0];
      rq.new_blocked = nb;
      return rq;
   endfunction

   function automatic stim_row_type csr_row(logic [gom_pkg::CSR_INDEX_W-1:0] idx,
                                            logic [gom_pkg::SIZE_W-1:0] val);
      stim_row_type s;
      s = '{default: '0};
      s.is_csr = 1'b1;
      s.reg_index = idx;
      s.reg_value = val;
      return s;
   endfunction

   function automatic stim_row_type req_row(logic [1:0] kind, int unsigned row,
                                            int unsigned col, bit nb);
      stim_row_type s;
      s = '{default: '0};
      s.rq = make_request(kind, row, col, nb);
      return s;
   endfunction

   function automatic stim_row_type chk_row(logic [1:0] kind, int unsigned row,
                                            int unsigned col, bit nb, bit blk,
                                            int unsigned nbr, int unsigned btot,
                                            int unsigned ftot,
                                            logic [gom_pkg::STATUS_W-1:0] st);
      stim_row_type s;
      s = req_row(kind, row, col, nb);
      s.typed = 1'b1;
      s.rsp.cell_blocked = blk;
      s.rsp.free_neighbours = nbr[gom_pkg::NBR_W-1:0];
      s.rsp.blocked_total = btot[gom_pkg::TOTAL_W-1:0];
      s.rsp.free_total = ftot[gom_pkg::TOTAL_W-1:0];
      s.rsp.status = st;
      return s;
   endfunction

   function automatic gom_pkg::request_type random_request();
      int unsigned rows;
      int unsigned cols;
      int unsigned k;
      logic [1:0] kind;
      int unsigned row;
      int unsigned col;
      rows = eff_size(rows_reg);
      cols = eff_size(cols_reg);
      k = $urandom_range(0, 99);
      if (k < 45) kind = gom_pkg::REQ_WRITE;
      else if (k < 65) kind = gom_pkg::REQ_READ;
      else if (k < 95) kind = gom_pkg::REQ_COUNT;
      else kind = gom_pkg::REQ_CLEAR;
      if ($urandom_range(0, 99) < 85 && rows > 0 && cols > 0) begin
         row = $urandom_range(0, rows - 1);
         col = $urandom_range(0, cols - 1);
      end else begin
         row = $urandom_range(0, 63);
         col = $urandom_range(0, 63);
      end
      return make_request(kind, row, col, $urandom_range(0, 99) < 60);
   endfunction

   function automatic logic [gom_pkg::SIZE_W-1:0] random_size();
      int unsigned k;
      k = $urandom_range(0, 9);
      if (k < 7) return gom_pkg::SIZE_W'($urandom_range(1, 8));
      if (k == 7) return gom_pkg::SIZE_W'($urandom_range(9, 64));
      if (k == 8) return gom_pkg::SIZE_W'($urandom_range(65, 127));
      return '0;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   task automatic issue_request(input gom_pkg::request_type rq, input bit use_typed,
                                input gom_pkg::response_type typed_rsp);
      gom_pkg::response_type predicted;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_grid_response(rq);
      pending_responses.push_back(use_typed ? typed_rsp : predicted);
   endtask

   task automatic idle_requests(input int unsigned n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic settle_grid();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_responses.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_grid_reg(input logic [gom_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [gom_pkg::SIZE_W-1:0] val);
      settle_grid();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == gom_pkg::CSR_GRID_ROWS) rows_reg = val;
      else cols_reg = val;
      wipe_grid();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic int unsigned random_gap();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 60) return 0;
      if (k < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   always @(posedge clock) begin
      gom_pkg::response_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("response with nothing expected");
         end else begin
            exp_rsp = pending_responses.pop_front();
            if (rsp_data.cell_blocked !== exp_rsp.cell_blocked)
               report_mismatch($sformatf("cell_blocked got %0d expected %0d",
                                         rsp_data.cell_blocked, exp_rsp.cell_blocked));
            if (rsp_data.free_neighbours !== exp_rsp.free_neighbours)
               report_mismatch($sformatf("free_neighbours got %0d expected %0d",
                                         rsp_data.free_neighbours, exp_rsp.free_neighbours));
            if (rsp_data.blocked_total !== exp_rsp.blocked_total)
               report_mismatch($sformatf("blocked_total got %0d expected %0d",
                                         rsp_data.blocked_total, exp_rsp.blocked_total));
            if (rsp_data.free_total !== exp_rsp.free_total)
               report_mismatch($sformatf("free_total got %0d expected %0d",
                                         rsp_data.free_total, exp_rsp.free_total));
            if (rsp_data.status !== exp_rsp.status)
               report_mismatch($sformatf("status got %0d expected %0d",
                                         rsp_data.status, exp_rsp.status));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int unsigned k;
      int unsigned n;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else begin
            k = $urandom_range(0, 99);
            if (k < 60) begin
               rsp_stall <= 1'b0;
               n = $urandom_range(1, 40);
            end else if (k < 90) begin
               rsp_stall <= 1'b1;
               n = $urandom_range(1, 3);
            end else begin
               rsp_stall <= 1'b1;
               n = $urandom_range(20, 80);
            end
            repeat (n - 1) @(negedge clock);
         end
      end
   end

   initial begin
      logic [gom_pkg::SIZE_W-1:0] nrows;
      logic [gom_pkg::SIZE_W-1:0] ncols;
      int unsigned n_items;
      bit burst;
      gom_pkg::response_type none;
      none = '0;
      rows_reg = gom_pkg::SIZE_RESET;
      cols_reg = gom_pkg::SIZE_RESET;
      wipe_grid();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      plan.push_back(chk_row(gom_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 4096, gom_pkg::STATUS_OK));
      plan.push_back(chk_row(gom_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 4096, gom_pkg::STATUS_SAME));
      plan.push_back(chk_row(gom_pkg::REQ_WRITE, 63, 63, 1, 1, 0, 1, 4095, gom_pkg::STATUS_OK));
      plan.push_back(chk_row(gom_pkg::REQ_WRITE, 63, 63, 1, 1, 0, 1, 4095,
                             gom_pkg::STATUS_SAME));
      plan.push_back(chk_row(gom_pkg::REQ_COUNT, 0, 0, 1, 0, 2, 1, 4095, gom_pkg::STATUS_OK));
      plan.push_back(req_row(gom_pkg::REQ_COUNT, 62, 63, 0));
      plan.push_back(req_row(gom_pkg::REQ_WRITE, 0, 0, 1));
      plan.push_back(req_row(gom_pkg::REQ_READ, 0, 0, 0));
      plan.push_back(req_row(gom_pkg::REQ_COUNT, 32, 17, 1));
      plan.push_back(chk_row(gom_pkg::REQ_WRITE, 0, 1, 0, 0, 0, 2, 4094, gom_pkg::STATUS_SAME));
      plan.push_back(req_row(gom_pkg::REQ_COUNT, 0, 1, 0));
      plan.push_back(chk_row(gom_pkg::REQ_CLEAR, 21, 42, 1, 0, 0, 0, 4096, gom_pkg::STATUS_OK));
      plan.push_back(csr_row(gom_pkg::CSR_GRID_ROWS, 7'd10));
      plan.push_back(csr_row(gom_pkg::CSR_GRID_COLS, 7'd5));
      plan.push_back(chk_row(gom_pkg::REQ_WRITE, 10, 0, 1, 0, 0, 0, 50, gom_pkg::STATUS_OOB));
      plan.push_back(chk_row(gom_pkg::REQ_READ, 0, 5, 0, 0, 0, 0, 50, gom_pkg::STATUS_OOB));
      plan.push_back(chk_row(gom_pkg::REQ_COUNT, 63, 63, 0, 0, 0, 0, 50, gom_pkg::STATUS_OOB));
      plan.push_back(req_row(gom_pkg::REQ_WRITE, 9, 4, 1));
      plan.push_back(req_row(gom_pkg::REQ_COUNT, 9, 3, 0));
      plan.push_back(csr_row(gom_pkg::CSR_GRID_ROWS, 7'd1));
      plan.push_back(csr_row(gom_pkg::CSR_GRID_COLS, 7'd3));
      plan.push_back(chk_row(gom_pkg::REQ_WRITE, 0, 0, 1, 0, 0, 0, 3, gom_pkg::STATUS_SMALL));
      plan.push_back(chk_row(gom_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 3, gom_pkg::STATUS_SMALL));
      plan.push_back(csr_row(gom_pkg::CSR_GRID_ROWS, 7'd0));
      plan.push_back(chk_row(gom_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, gom_pkg::STATUS_SMALL));
      plan.push_back(csr_row(gom_pkg::CSR_GRID_ROWS, 7'd127));
      plan.push_back(csr_row(gom_pkg::CSR_GRID_COLS, 7'd127));
      plan.push_back(chk_row(gom_pkg::REQ_READ, 63, 63, 0, 0, 0, 0, 4096, gom_pkg::STATUS_OK));
      plan.push_back(chk_row(gom_pkg::REQ_WRITE, 63, 0, 1, 1, 0, 1, 4095, gom_pkg::STATUS_OK));

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            write_grid_reg(plan[i].reg_index, plan[i].reg_value);
         end else begin
            issue_request(plan[i].rq, plan[i].typed, plan[i].rsp);
            idle_requests(random_gap());
         end
      end

      for (int p = 0; p < 12; p++) begin
         case (p)
            0: begin nrows = 7'd64;  ncols = 7'd64;  end
            1: begin nrows = 7'd2;   ncols = 7'd2;   end
            2: begin nrows = 7'd1;   ncols = 7'd4;   end
            3: begin nrows = 7'd127; ncols = 7'd1;   end
            4: begin nrows = 7'd3;   ncols = 7'd1;   end
            5: begin nrows = 7'd0;   ncols = 7'd5;   end
            6: begin nrows = 7'd64;  ncols = 7'd127; end
            default: begin nrows = random_size(); ncols = random_size(); end
         endcase
         write_grid_reg(gom_pkg::CSR_GRID_ROWS, nrows);
         write_grid_reg(gom_pkg::CSR_GRID_COLS, ncols);
         n_items = (p == 4 || p == 5) ? 30 : 80;
         burst = (p % 3 == 0);
         if (p == 0) hold_rsp = 1'b1;
         for (int i = 0; i < n_items; i++) begin
            if (i == 35 && p % 4 == 1) settle_grid();
            issue_request(random_request(), 1'b0, none);
            if (!burst) idle_requests(random_gap());
         end
      end

      settle_grid();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_responses.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
